>>> design/h264ro_pkg.sv
`timescale 1ns / 1ps

package h264ro_pkg;

  localparam int REORDER_DEPTH_DEF = 16;
  localparam int MAP_DEPTH_DEF     = 4096;

  localparam int CMD_W  = 2;
  localparam int OC_W   = 32;
  localparam int IDX_W  = 12;
  localparam int KIND_W = 2;
  localparam int OFS_W  = 14;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FLUSH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [KIND_W-1:0] KIND_PLACE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_OFFSET = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL   = 2'd2;

  typedef struct packed {
    logic load;
    logic q_read;
    logic clear_step;
    logic insert;
    logic scan_init;
    logic scan_step;
    logic remove;
    logic last;
    logic emit_full;
    logic emit_query;
  } dp_cmd_t;

  typedef struct packed {
    logic in_add;
    logic in_flush;
    logic in_query;
    logic in_idr;
    logic map_full;
    logic slots_empty;
    logic will_fill;
    logic drain_last;
    logic scan_done;
    logic out_free;
    logic clear_last;
  } dp_status_t;

endpackage

>>> design/h264ro_in_if.sv
`timescale 1ns / 1ps

interface h264ro_in_if;
  import h264ro_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        command;
  logic signed [OC_W-1:0]  order_count;
  logic                    is_idr;
  logic [IDX_W-1:0]        query_index;

  modport source (output valid, output command, output order_count, output is_idr,
                  output query_index, input ready);
  modport sink (input valid, input command, input order_count, input is_idr,
                input query_index, output ready);
endinterface

>>> design/h264ro_out_if.sv
`timescale 1ns / 1ps

interface h264ro_out_if;
  import h264ro_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic [IDX_W-1:0]        decode_index;
  logic [IDX_W-1:0]        output_order;
  logic signed [OFS_W-1:0] offset;
  logic                    last;

  modport source (output valid, output kind, output decode_index, output output_order,
                  output offset, output last, input ready);
  modport sink (input valid, input kind, input decode_index, input output_order,
                input offset, input last, output ready);
endinterface

>>> design/h264ro_ctrl.sv
`timescale 1ns / 1ps

module h264ro_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  h264ro_pkg::dp_status_t status,
  output h264ro_pkg::dp_cmd_t    cmd
);
  import h264ro_pkg::*;

  localparam logic [2:0] S_CLEAR     = 3'd0;
  localparam logic [2:0] S_IDLE      = 3'd1;
  localparam logic [2:0] S_INSERT    = 3'd2;
  localparam logic [2:0] S_SCAN_INIT = 3'd3;
  localparam logic [2:0] S_SCAN      = 3'd4;
  localparam logic [2:0] S_REMOVE    = 3'd5;
  localparam logic [2:0] S_FULL      = 3'd6;
  localparam logic [2:0] S_QUERY     = 3'd7;

  logic [2:0] state, state_next;
  logic       drain, drain_next;
  logic       then_insert, then_insert_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      drain       <= 1'b0;
      then_insert <= 1'b0;
    end else begin
      state       <= state_next;
      drain       <= drain_next;
      then_insert <= then_insert_next;
    end
  end

  always_comb begin
    state_next       = state;
    drain_next       = drain;
    then_insert_next = then_insert;
    cmd              = '0;
    in_ready         = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (status.in_add) begin
            if (status.map_full) begin
              state_next = S_FULL;
            end else if (status.in_idr && !status.slots_empty) begin
              drain_next       = 1'b1;
              then_insert_next = 1'b1;
              state_next       = S_SCAN_INIT;
            end else begin
              state_next = S_INSERT;
            end
          end else if (status.in_flush) begin
            if (!status.slots_empty) begin
              drain_next       = 1'b1;
              then_insert_next = 1'b0;
              state_next       = S_SCAN_INIT;
            end
          end else if (status.in_query) begin
            cmd.q_read = 1'b1;
            state_next = S_QUERY;
          end
        end
      end
      S_INSERT: begin
        cmd.insert = 1'b1;
        if (status.will_fill) begin
          drain_next       = 1'b0;
          then_insert_next = 1'b0;
          state_next       = S_SCAN_INIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SCAN_INIT: begin
        cmd.scan_init = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_done) state_next = S_REMOVE;
        else cmd.scan_step = 1'b1;
      end
      S_REMOVE: begin
        if (status.out_free) begin
          cmd.remove = 1'b1;
          cmd.last   = !drain || status.drain_last;
          if (drain && !status.drain_last) state_next = S_SCAN_INIT;
          else if (drain && then_insert) state_next = S_INSERT;
          else state_next = S_IDLE;
        end
      end
      S_FULL: begin
        if (status.out_free) begin
          cmd.emit_full = 1'b1;
          state_next    = S_IDLE;
        end
      end
      S_QUERY: begin
        if (status.out_free) begin
          cmd.emit_query = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> design/h264ro_datapath.sv
`timescale 1ns / 1ps

module h264ro_datapath #(
  parameter int REORDER_DEPTH = h264ro_pkg::REORDER_DEPTH_DEF,
  parameter int MAP_DEPTH     = h264ro_pkg::MAP_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [h264ro_pkg::CMD_W-1:0]          command,
  input  logic signed [h264ro_pkg::OC_W-1:0]    order_count,
  input  logic                                  is_idr,
  input  logic [h264ro_pkg::IDX_W-1:0]          query_index,
  h264ro_out_if.source                          out_stream,
  input  h264ro_pkg::dp_cmd_t                   cmd,
  output h264ro_pkg::dp_status_t                status
);
  import h264ro_pkg::*;

  localparam int AW  = $clog2(MAP_DEPTH);
  localparam int CW  = $clog2(MAP_DEPTH + 1);
  localparam int SW  = $clog2(REORDER_DEPTH);
  localparam int SCW = $clog2(REORDER_DEPTH + 1);
  localparam int QW  = (CW > IDX_W) ? CW : IDX_W;
  localparam int OW  = QW + 2;
  localparam int PW  = AW + IDX_W;

  logic [AW-1:0]          slot_didx [REORDER_DEPTH];
  logic signed [OC_W-1:0] slot_oc   [REORDER_DEPTH];
  logic [SCW-1:0]         slot_count;
  logic [CW-1:0]          next_idx;
  logic [CW-1:0]          placed;
  logic [SW-1:0]          min_depth;

  logic [SCW-1:0]         scan_idx;
  logic [SW-1:0]          best_pos;
  logic signed [OC_W-1:0] best_oc;
  logic [AW-1:0]          best_didx;
  logic signed [OC_W-1:0] cand_oc;
  logic [AW-1:0]          cand_didx;

  logic [IDX_W-1:0]       q_reg;
  logic signed [OC_W-1:0] oc_reg;

  logic [AW:0]            order_map [MAP_DEPTH];
  logic [AW:0]            rdata;
  logic [AW-1:0]          clr_addr;
  logic                   map_we;
  logic [AW-1:0]          map_waddr;
  logic [AW:0]            map_wdata;
  logic [QW-1:0]          q_live_ext;
  logic [AW-1:0]          q_addr;

  logic [QW-1:0]          q_ext;
  logic [QW-1:0]          placed_ext;
  logic                   q_out_range;
  logic [OW-1:0]          ofs_sum;
  logic [OW-1:0]          q_ofs;
  logic [PW-1:0]          didx_pad;
  logic [PW-1:0]          oord_pad;

  logic                   out_valid;
  logic                   emit;

  assign emit             = cmd.remove || cmd.emit_full || cmd.emit_query;
  assign out_stream.valid = out_valid;

  assign status.in_add      = command == CMD_ADD;
  assign status.in_flush    = command == CMD_FLUSH;
  assign status.in_query    = command == CMD_QUERY;
  assign status.in_idr      = is_idr;
  assign status.map_full    = next_idx >= CW'(MAP_DEPTH);
  assign status.slots_empty = slot_count == '0;
  assign status.will_fill   = slot_count == SCW'(REORDER_DEPTH - 1);
  assign status.drain_last  = slot_count == SCW'(1);
  assign status.scan_done   = scan_idx >= slot_count;
  assign status.out_free    = !out_valid || out_stream.ready;
  assign status.clear_last  = clr_addr == AW'(MAP_DEPTH - 1);

  assign cand_oc   = slot_oc[scan_idx[SW-1:0]];
  assign cand_didx = slot_didx[scan_idx[SW-1:0]];

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
      next_idx   <= '0;
      placed     <= '0;
      min_depth  <= '0;
      clr_addr   <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_addr <= clr_addr + 1'b1;
      if (cmd.insert) begin
        slot_count <= slot_count + 1'b1;
        next_idx   <= next_idx + 1'b1;
      end
      if (cmd.remove) begin
        slot_count <= slot_count - 1'b1;
        placed     <= placed + 1'b1;
        if (best_pos > min_depth) min_depth <= best_pos;
      end
      if (emit) out_valid <= 1'b1;
      else if (out_stream.ready) out_valid <= 1'b0;
    end
  end

  // reorder slots: append on insert, close the gap on removal
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      slot_didx[slot_count[SW-1:0]] <= next_idx[AW-1:0];
      slot_oc[slot_count[SW-1:0]]   <= oc_reg;
    end else if (cmd.remove) begin
      for (int i = 0; i < REORDER_DEPTH - 1; i++) begin
        if (SW'(i) >= best_pos) begin
          slot_didx[i] <= slot_didx[i + 1];
          slot_oc[i]   <= slot_oc[i + 1];
        end
      end
    end
  end

  // lowest order count search, first minimum wins
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      q_reg  <= query_index;
      oc_reg <= order_count;
    end
    if (cmd.scan_init) begin
      best_oc   <= slot_oc[0];
      best_didx <= slot_didx[0];
      best_pos  <= '0;
      scan_idx  <= SCW'(1);
    end else if (cmd.scan_step) begin
      if (cand_oc < best_oc) begin
        best_oc   <= cand_oc;
        best_didx <= cand_didx;
        best_pos  <= scan_idx[SW-1:0];
      end
      scan_idx <= scan_idx + 1'b1;
    end
  end

  // order map: {placed, output order}
  assign q_live_ext = QW'(query_index);
  assign q_addr     = q_live_ext[AW-1:0];
  assign map_we     = cmd.clear_step || cmd.remove;
  assign map_waddr  = cmd.clear_step ? clr_addr : best_didx;
  assign map_wdata  = cmd.clear_step ? '0 : {1'b1, placed[AW-1:0]};

  always_ff @(posedge clk) begin
    if (map_we) order_map[map_waddr] <= map_wdata;
    if (cmd.q_read) rdata <= order_map[q_addr];
  end

  assign q_ext       = QW'(q_reg);
  assign placed_ext  = QW'(placed);
  assign q_out_range = (q_ext >= placed_ext) || (q_ext >= QW'(MAP_DEPTH));
  assign ofs_sum     = OW'(min_depth) + OW'(rdata[AW-1:0]) - OW'(q_reg);

  always_comb begin
    if (q_out_range) q_ofs = '0;
    else if (!rdata[AW]) q_ofs = OW'(min_depth);
    else q_ofs = ofs_sum;
  end

  assign didx_pad = PW'(best_didx);
  assign oord_pad = PW'(placed[AW-1:0]);

  // result register
  always_ff @(posedge clk) begin
    if (cmd.remove) begin
      out_stream.kind         <= KIND_PLACE;
      out_stream.decode_index <= didx_pad[IDX_W-1:0];
      out_stream.output_order <= oord_pad[IDX_W-1:0];
      out_stream.offset       <= '0;
      out_stream.last         <= cmd.last;
    end else if (cmd.emit_full) begin
      out_stream.kind         <= KIND_FULL;
      out_stream.decode_index <= '0;
      out_stream.output_order <= '0;
      out_stream.offset       <= '0;
      out_stream.last         <= 1'b1;
    end else if (cmd.emit_query) begin
      out_stream.kind         <= KIND_OFFSET;
      out_stream.decode_index <= q_reg;
      out_stream.output_order <= '0;
      out_stream.offset       <= signed'(q_ofs[OFS_W-1:0]);
      out_stream.last         <= 1'b1;
    end
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> status.out_free)
    else $error("result loaded while output register still held");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    slot_count <= SCW'(REORDER_DEPTH))
    else $error("slot count past buffer depth");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> (slot_count < SCW'(REORDER_DEPTH)) && !status.map_full)
    else $error("insert without room");

  a_placed_le_next: assert property (@(posedge clk) disable iff (rst)
    placed <= next_idx)
    else $error("more pictures placed than added");

  a_place_step: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |=> placed == CW'($past(placed) + 1'b1))
    else $error("placed count did not advance on removal");

endmodule

>>> design/h264_reorder_buffer_offsets_top.sv
`timescale 1ns / 1ps

// Picture reorder buffer with composition offset lookup.
// in_stream carries commands: add picture (order_count, is_idr), flush, and
// offset query (query_index). out_stream carries results: placements, offset
// answers and full-map notices; last marks the final result of a command.
// Both channels move a transaction when valid and ready are high together.
// After reset the order map is swept to unplaced, one entry per cycle;
// in_stream.ready stays low until the sweep ends.
// One command is worked at a time; in_stream.ready is high only when idle.
// An add loads the command and then inserts the picture; a query reads
// the order map and then loads the result. Each removal runs the
// one-slot-per-cycle minimum search, then removes the lowest entry once
// the output register is free; an add that fills the buffer ends with a
// removal. A flush or IDR drain repeats removals until the buffer is empty.
// Results sit in one output register; a stalled receiver holds the current
// transaction and the controller waits before loading the next one.
module h264_reorder_buffer_offsets_top #(
  parameter int REORDER_DEPTH = h264ro_pkg::REORDER_DEPTH_DEF,
  parameter int MAP_DEPTH     = h264ro_pkg::MAP_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  h264ro_in_if.sink    in_stream,
  h264ro_out_if.source out_stream
);
  import h264ro_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       in_ready;

  assign in_stream.ready = in_ready;

  h264ro_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_stream.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  h264ro_datapath #(
    .REORDER_DEPTH (REORDER_DEPTH),
    .MAP_DEPTH     (MAP_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .command     (in_stream.command),
    .order_count (in_stream.order_count),
    .is_idr      (in_stream.is_idr),
    .query_index (in_stream.query_index),
    .out_stream  (out_stream),
    .cmd         (cmd),
    .status      (status)
  );

endmodule

>>> dv/h264ro_offset_check.sv
`timescale 1ns / 1ps

module h264ro_offset_check #(
  parameter int REORDER_DEPTH = h264ro_pkg::REORDER_DEPTH_DEF,
  parameter int MAP_DEPTH     = h264ro_pkg::MAP_DEPTH_DEF
) (
  input  logic  clk,
  input  logic  rst,
  h264ro_in_if  in_mon,
  h264ro_out_if out_mon,
  output int    mismatches,
  output int    outstanding
);
  import h264ro_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        decode_index;
    logic [IDX_W-1:0]        output_order;
    logic signed [OFS_W-1:0] offset;
    logic                    last;
  } result_t;

  logic [IDX_W-1:0]       slot_idx [REORDER_DEPTH];
  logic signed [OC_W-1:0] slot_poc [REORDER_DEPTH];
  int                     slot_cnt;
  int                     next_idx;
  int                     placed_cnt;
  int                     min_depth;
  int                     out_pos [MAP_DEPTH];
  bit                     is_placed [MAP_DEPTH];
  result_t                expected_q [$];
  result_t                batch [$];

  task automatic report_mismatch(input string msg);
    if (mismatches < 50) $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void emit(logic [KIND_W-1:0] kind, logic [IDX_W-1:0] didx,
                               logic [IDX_W-1:0] oord, logic signed [OFS_W-1:0] ofs);
    result_t r;
    r.kind         = kind;
    r.decode_index = didx;
    r.output_order = oord;
    r.offset       = ofs;
    r.last         = 1'b0;
    batch.push_back(r);
  endfunction

  // pull the lowest POC out of the buffer; ties go to the entry nearest the head
  function automatic void place_lowest_poc();
    int pos;
    int d;
    pos = 0;
    for (int i = 1; i < slot_cnt; i++) begin
      if (slot_poc[i] < slot_poc[pos]) pos = i;
    end
    d = int'(slot_idx[pos]);
    out_pos[d]   = placed_cnt;
    is_placed[d] = 1'b1;
    emit(KIND_PLACE, d[IDX_W-1:0], placed_cnt[IDX_W-1:0], '0);
    placed_cnt++;
    if (pos > min_depth) min_depth = pos;
    for (int i = pos; i + 1 < slot_cnt; i++) begin
      slot_idx[i] = slot_idx[i+1];
      slot_poc[i] = slot_poc[i+1];
    end
    slot_cnt--;
  endfunction

  function automatic void predict_results(logic [CMD_W-1:0] cmd, logic signed [OC_W-1:0] poc,
                                          logic idr, logic [IDX_W-1:0] q);
    int qi;
    int ofs;
    qi = int'(q);
    batch.delete();
    case (cmd)
      CMD_ADD: begin
        if (next_idx >= MAP_DEPTH) begin
          emit(KIND_FULL, '0, '0, '0);
        end else begin
          if (idr) begin
            while (slot_cnt > 0) place_lowest_poc();
          end
          if (slot_cnt < REORDER_DEPTH) begin
            slot_idx[slot_cnt] = next_idx[IDX_W-1:0];
            slot_poc[slot_cnt] = poc;
            slot_cnt++;
          end
          next_idx++;
          if (slot_cnt >= REORDER_DEPTH) place_lowest_poc();
        end
      end
      CMD_FLUSH: begin
        while (slot_cnt > 0) place_lowest_poc();
      end
      CMD_QUERY: begin
        if (qi >= placed_cnt || qi >= MAP_DEPTH) ofs = 0;
        else if (!is_placed[qi]) ofs = min_depth;
        else ofs = min_depth + out_pos[qi] - qi;
        emit(KIND_OFFSET, q, '0, ofs[OFS_W-1:0]);
      end
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[i]) expected_q.push_back(batch[i]);
  endfunction

  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      slot_cnt   = 0;
      next_idx   = 0;
      placed_cnt = 0;
      min_depth  = 0;
      foreach (is_placed[i]) is_placed[i] = 1'b0;
      foreach (out_pos[i]) out_pos[i] = 0;
      expected_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        predict_results(in_mon.command, in_mon.order_count, in_mon.is_idr, in_mon.query_index);
      end
      if (out_mon.valid && out_mon.ready) begin
        got.kind         = out_mon.kind;
        got.decode_index = out_mon.decode_index;
        got.output_order = out_mon.output_order;
        got.offset       = out_mon.offset;
        got.last         = out_mon.last;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction kind %0d idx %0d order %0d ofs %0d",
                                    got.kind, got.decode_index, got.output_order, got.offset));
        end else begin
          want = expected_q.pop_front();
          if (got.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
          if (got.decode_index !== want.decode_index)
            report_mismatch($sformatf("decode_index %0d, want %0d",
                                      got.decode_index, want.decode_index));
          if (got.output_order !== want.output_order)
            report_mismatch($sformatf("output_order %0d, want %0d",
                                      got.output_order, want.output_order));
          if (got.offset !== want.offset)
            report_mismatch($sformatf("offset %0d, want %0d", got.offset, want.offset));
          if (got.last !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
        end
      end
    end
    outstanding <= expected_q.size();
  end

endmodule

>>> dv/h264_reorder_buffer_offsets_top_tb.sv
`timescale 1ns / 1ps

module h264_reorder_buffer_offsets_top_tb;
  import h264ro_pkg::*;

  localparam int REORDER_DEPTH = REORDER_DEPTH_DEF;
  localparam int MAP_DEPTH     = MAP_DEPTH_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 105;

  typedef enum int {POC_RISING, POC_FALLING, POC_RANDOM, POC_FLAT} poc_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  int                     gap_pct   = 0;
  int                     stall_pct = 0;
  int                     adds_sent = 0;
  int                     run_left  = 0;
  poc_style_t             poc_style = POC_RISING;
  logic signed [OC_W-1:0] poc_base  = '0;
  int                     mismatches;
  int                     outstanding;

  h264ro_in_if  in_ch ();
  h264ro_out_if out_ch ();

  h264_reorder_buffer_offsets_top #(
    .REORDER_DEPTH(REORDER_DEPTH),
    .MAP_DEPTH    (MAP_DEPTH)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .in_stream (in_ch),
    .out_stream(out_ch)
  );

  h264ro_offset_check #(
    .REORDER_DEPTH(REORDER_DEPTH),
    .MAP_DEPTH    (MAP_DEPTH)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always #5 clk = ~clk;

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic signed [OC_W-1:0] poc,
                          input logic idr, input logic [IDX_W-1:0] qi);
    while ($urandom_range(99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.command     <= cmd;
    in_ch.order_count <= poc;
    in_ch.is_idr      <= idr;
    in_ch.query_index <= qi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (cmd == CMD_ADD) adds_sent++;
  endtask

  function automatic logic [IDX_W-1:0] near_index();
    int hi;
    hi = (adds_sent + 2 > MAP_DEPTH - 1) ? MAP_DEPTH - 1 : adds_sent + 2;
    return IDX_W'($urandom_range(hi));
  endfunction

  task automatic send_picture(input logic idr);
    int r;
    logic signed [OC_W-1:0] poc;
    if (run_left == 0) begin
      r = $urandom_range(99);
      if (r < 60) poc_style = POC_RISING;
      else if (r < 75) poc_style = POC_FALLING;
      else if (r < 90) poc_style = POC_RANDOM;
      else poc_style = POC_FLAT;
      run_left = $urandom_range(24, 8);
    end
    run_left--;
    if (idr) poc_base = '0;
    case (poc_style)
      POC_RISING: begin
        poc = poc_base + int'($urandom_range(6)) - 3;
        poc_base += 2;
      end
      POC_FALLING: begin
        poc = poc_base;
        poc_base -= int'($urandom_range(4, 1));
      end
      POC_RANDOM: poc = $urandom;
      default: poc = poc_base;
    endcase
    send_cmd(CMD_ADD, poc, idr, IDX_W'($urandom));
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(99);
    if (r < 60) begin
      send_picture($urandom_range(24) == 0);
    end else if (r < 90) begin
      if ($urandom_range(3) == 0) send_cmd(CMD_QUERY, $urandom, 1'($urandom), IDX_W'($urandom));
      else send_cmd(CMD_QUERY, $urandom, 1'($urandom), near_index());
    end else if (r < 95) begin
      send_cmd(CMD_FLUSH, $urandom, 1'($urandom), IDX_W'($urandom));
    end else begin
      send_cmd(CMD_W'($urandom), $urandom, 1'($urandom), IDX_W'($urandom));
    end
  endtask

  initial begin
    in_ch.valid       <= 1'b0;
    in_ch.command     <= CMD_ADD;
    in_ch.order_count <= '0;
    in_ch.is_idr      <= 1'b0;
    in_ch.query_index <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_cmd(CMD_QUERY, '0, 1'b0, '0);
    send_cmd(CMD_QUERY, '1, 1'b1, '1);
    send_cmd(CMD_FLUSH, '0, 1'b0, '0);
    send_cmd(CMD_UNUSED, '1, 1'b1, '1);
    send_cmd(CMD_ADD, 32'sh7FFF_FFFF, 1'b0, '0);
    send_cmd(CMD_ADD, 32'sh8000_0000, 1'b0, '0);
    send_cmd(CMD_ADD, '0, 1'b0, '0);
    send_cmd(CMD_ADD, -32'sd1, 1'b0, '0);
    send_cmd(CMD_ADD, -32'sd1, 1'b0, '1);
    send_cmd(CMD_FLUSH, '0, 1'b0, '0);
    send_cmd(CMD_QUERY, '0, 1'b0, 12'd0);
    send_cmd(CMD_QUERY, '0, 1'b0, 12'd1);
    send_cmd(CMD_QUERY, '0, 1'b0, 12'd4);
    send_cmd(CMD_QUERY, '0, 1'b0, 12'd5);
    send_cmd(CMD_ADD, 32'sd10, 1'b1, '0);
    send_cmd(CMD_ADD, 32'sd4, 1'b0, '0);
    send_cmd(CMD_ADD, -32'sd7, 1'b1, '0);
    send_cmd(CMD_QUERY, '0, 1'b0, 12'd7);
    send_cmd(CMD_QUERY, '0, 1'b0, 12'd6);
    send_cmd(CMD_FLUSH, '0, 1'b0, '0);
    send_cmd(CMD_QUERY, '0, 1'b0, 12'd7);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct   = 47;
          stall_pct = 0;
        end
        2: begin
          gap_pct   = 0;
          stall_pct = 47;
        end
        default: begin
          gap_pct   = 35;
          stall_pct = 35;
        end
      endcase
      repeat (PHASE_ITEMS) random_item();
    end

    gap_pct   = 0;
    stall_pct = 0;
    send_cmd(CMD_ADD, $urandom, 1'b1, IDX_W'($urandom));
    send_cmd(CMD_QUERY, $urandom, 1'($urandom), '1);
    send_cmd(CMD_QUERY, $urandom, 1'($urandom), '0);
    send_cmd(CMD_FLUSH, $urandom, 1'($urandom), IDX_W'($urandom));
    send_cmd(CMD_QUERY, $urandom, 1'($urandom), '1);
    gap_pct   = 35;
    stall_pct = 35;
    repeat (8) send_cmd(CMD_QUERY, $urandom, 1'($urandom), IDX_W'($urandom));

    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (400) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
design/h264ro_pkg.sv
design/h264ro_in_if.sv
design/h264ro_out_if.sv
design/h264ro_ctrl.sv
design/h264ro_datapath.sv
design/h264_reorder_buffer_offsets_top.sv
dv/h264ro_offset_check.sv
dv/h264_reorder_buffer_offsets_top_tb.sv
